// ----- hw/rtl/acrf_pkg.sv -----
// Package for the codec mixer register file: types, address codes and the
// power-on default table. No dependencies.
`default_nettype none

package acrf_pkg;

  localparam int WORD_COUNT = 64;
  localparam int IDX_W      = $clog2(WORD_COUNT);
  localparam int WORD_W     = 16;
  localparam int ADDR_W     = 8;
  localparam int VID_W      = 32;

  // Byte addresses with special write rules (exact match only)
  localparam logic [ADDR_W-1:0] ADDR_RESET      = 8'h00;
  localparam logic [ADDR_W-1:0] ADDR_PWR_STATUS = 8'h26;
  localparam logic [ADDR_W-1:0] ADDR_EXT_ID     = 8'h28;
  localparam logic [ADDR_W-1:0] ADDR_DAC_RATE   = 8'h2c;
  localparam logic [ADDR_W-1:0] ADDR_ADC_RATE   = 8'h32;
  localparam logic [ADDR_W-1:0] ADDR_MIC_RATE   = 8'h34;
  localparam logic [ADDR_W-1:0] ADDR_VID_HI     = 8'h7c;
  localparam logic [ADDR_W-1:0] ADDR_VID_LO     = 8'h7e;

  localparam logic [ADDR_W-1:0] WORD_ADDR_MASK  = 8'h7f;
  localparam logic [WORD_W-1:0] READY_LOW_BITS  = 16'h000f;
  localparam logic [WORD_W-1:0] RATE_48K        = 16'd48000;
  localparam logic [WORD_W-1:0] DFLT_MUTE       = 16'h8000;
  localparam logic [WORD_W-1:0] DFLT_MUTE_LR    = 16'h8008;
  localparam logic [WORD_W-1:0] DFLT_MUTE_GAIN  = 16'h8808;

  // Word indexes of the default table
  localparam logic [IDX_W-1:0] W_MASTER     = 6'd1;
  localparam logic [IDX_W-1:0] W_MONO       = 6'd3;
  localparam logic [IDX_W-1:0] W_PHONE      = 6'd6;
  localparam logic [IDX_W-1:0] W_MIC        = 6'd7;
  localparam logic [IDX_W-1:0] W_LINE       = 6'd8;
  localparam logic [IDX_W-1:0] W_CD         = 6'd9;
  localparam logic [IDX_W-1:0] W_PCM        = 6'd12;
  localparam logic [IDX_W-1:0] W_REC_GAIN   = 6'd14;
  localparam logic [IDX_W-1:0] W_PWR_STATUS = 6'd19;
  localparam logic [IDX_W-1:0] W_DAC_RATE   = 6'd22;
  localparam logic [IDX_W-1:0] W_ADC_RATE   = 6'd25;
  localparam logic [IDX_W-1:0] W_MIC_RATE   = 6'd26;
  localparam logic [IDX_W-1:0] W_VID_HI     = 6'd62;
  localparam logic [IDX_W-1:0] W_VID_LO     = 6'd63;

  typedef struct packed {
    logic              is_write;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } req_t;

  function automatic logic [IDX_W-1:0] word_idx(input logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] masked;
    masked   = addr & WORD_ADDR_MASK;
    word_idx = masked[IDX_W:1];
  endfunction

  function automatic logic is_read_only(input logic [ADDR_W-1:0] addr);
    is_read_only = (addr == ADDR_EXT_ID)   || (addr == ADDR_DAC_RATE) ||
                   (addr == ADDR_ADC_RATE) || (addr == ADDR_MIC_RATE) ||
                   (addr == ADDR_VID_HI)   || (addr == ADDR_VID_LO);
  endfunction

  function automatic logic [WORD_W-1:0] default_word(input logic [IDX_W-1:0] idx,
                                                      input logic [VID_W-1:0] vid);
    logic [WORD_W-1:0] w;
    w = '0;
    unique case (idx)
      W_MASTER, W_MONO, W_REC_GAIN: w = DFLT_MUTE;
      W_PHONE, W_MIC:               w = DFLT_MUTE_LR;
      W_LINE, W_CD, W_PCM:          w = DFLT_MUTE_GAIN;
      W_PWR_STATUS:                 w = READY_LOW_BITS;
      W_DAC_RATE, W_ADC_RATE, W_MIC_RATE: w = RATE_48K;
      W_VID_HI:                     w = vid[VID_W-1:WORD_W];
      W_VID_LO:                     w = vid[WORD_W-1:0];
      default:                      w = '0;
    endcase
    default_word = w;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/acrf_in_reg.sv -----
// Input register for the mixer register file: captures one request
// transaction and holds it until the store stage takes it. Uses acrf_pkg.
`default_nettype none

module acrf_in_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire acrf_pkg::req_t in_req,
  input  wire logic          advance,
  output logic               req_valid,
  output acrf_pkg::req_t     req
);
  import acrf_pkg::*;

  logic valid_r, valid_nxt;
  req_t req_r;
  logic accept;

  assign in_stall = valid_r & ~advance;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
  end

  assign req_valid = valid_r;
  assign req       = req_r;

endmodule

`default_nettype wire

// ----- hw/rtl/acrf_store.sv -----
// Word store and result register: 64x16 memory, per-word valid bits that
// fall back to the default table, and the registered answer. Uses acrf_pkg.
`default_nettype none

module acrf_store (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     req_valid,
  input  wire acrf_pkg::req_t           req,
  input  wire logic [acrf_pkg::VID_W-1:0] codec_vid,
  output logic                          advance,
  input  wire logic                     out_stall,
  output logic                          out_valid,
  output logic [acrf_pkg::WORD_W-1:0]   read_data,
  output logic                          ready_res
);
  import acrf_pkg::*;

  logic [WORD_W-1:0]     mem [WORD_COUNT];
  logic [WORD_W-1:0]     mem_q_r;
  logic [WORD_COUNT-1:0] vld_r, vld_nxt;
  logic [VID_W-1:0]      vid_snap_r, vid_snap_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  is_rd_r, hit_r;
  logic [WORD_W-1:0]     dflt_r;

  logic [IDX_W-1:0]  idx;
  logic              reload, mem_we;
  logic [WORD_W-1:0] wdata;

  assign advance = req_valid & (~out_valid_r | ~out_stall);
  assign idx     = word_idx(req.addr);
  assign reload  = advance & req.is_write & (req.addr == ADDR_RESET);
  assign mem_we  = advance & req.is_write & (req.addr != ADDR_RESET) &
                   ~is_read_only(req.addr);
  assign wdata   = (req.addr == ADDR_PWR_STATUS) ? (req.data | READY_LOW_BITS) : req.data;

  always_comb begin
    vld_nxt      = vld_r;
    vid_snap_nxt = vid_snap_r;
    if (reload) begin
      vld_nxt      = '0;
      vid_snap_nxt = codec_vid;
    end else if (mem_we) begin
      vld_nxt[idx] = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      vid_snap_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      vid_snap_r  <= vid_snap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx] <= wdata;
    end
    if (advance) begin
      mem_q_r <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      is_rd_r <= ~req.is_write;
      hit_r   <= vld_r[idx];
      dflt_r  <= default_word(idx, vid_snap_r);
    end
  end

  assign out_valid = out_valid_r;
  assign read_data = !is_rd_r ? '0 : (hit_r ? mem_q_r : dflt_r);
  assign ready_res = is_rd_r;

endmodule

`default_nettype wire

// ----- hw/rtl/audio_codec_register_file_top.sv -----
// Top level of the codec mixer register file: vendor ID register, input
// register and word store. Uses acrf_pkg, acrf_in_reg and acrf_store.
`default_nettype none

// One transaction per clock while out_stall is low: a request is captured in the
// input register, and when the store stage advances it reads or writes the
// 64-word store and its answer lands in the result register, which drives the
// output; a new request can be taken every cycle unless out_stall holds the
// result register. The memory port (one access per cycle) sets that rate. Reads
// return the word with out_ready_res set; writes return zero with it clear. A
// write to byte 0x00 restores all defaults at once through per-word valid bits
// and latches the current vendor ID into words 62/63; there is no clearing pass.
// The vendor ID register only reaches the words on such a reload (after reset
// the ID words read zero).
module audio_codec_register_file_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_address,
  input  wire logic [15:0] in_write_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_read_data,
  output logic             out_ready_res,
  input  wire logic        cfg_write_en,
  input  wire logic [31:0] cfg_write_data
);
  import acrf_pkg::*;

  logic [VID_W-1:0] codec_vid_r;
  req_t             in_req, req;
  logic             req_valid, advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_vid_r <= '0;
    end else if (cfg_write_en) begin
      codec_vid_r <= cfg_write_data;
    end
  end

  always_comb begin
    in_req.is_write = in_action;
    in_req.addr     = in_address;
    in_req.data     = in_write_data;
  end

  acrf_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .advance   (advance),
    .req_valid (req_valid),
    .req       (req)
  );

  acrf_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req       (req),
    .codec_vid (codec_vid_r),
    .advance   (advance),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .read_data (out_read_data),
    .ready_res (out_ready_res)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/acrf_checker.sv -----
// Port-level checks for the codec mixer register file, bound to the top
// level. No package dependencies.
`default_nettype none

module acrf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_read_data,
  input wire logic        out_ready_res
);

  // held result does not move while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data) && $stable(out_ready_res))
    else $error("result changed while stalled");

  // write answers carry zero data
  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready_res |-> out_read_data == 16'h0000)
    else $error("write answer with nonzero data");

  // every accepted transaction is followed by a valid result on the output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> ##2 out_valid)
    else $error("result missing after accept");

  // empty after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind audio_codec_register_file_top acrf_checker u_acrf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_read_data (out_read_data),
  .out_ready_res (out_ready_res)
);

`default_nettype wire

// ----- verif/audio_codec_register_file_top_test.sv -----
// Testbench for audio_codec_register_file_top: a directed table, then random
// read/write traffic across several vendor IDs, checked against a mixer-word model.
// Depends on acrf_pkg and the RTL under hw/rtl.
`timescale 1ns / 100ps

module audio_codec_register_file_top_test;
  import acrf_pkg::*;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;
  localparam int   IDLE_LIMIT      = 2000;
  localparam int   ITEMS_PER_PHASE = 360;
  localparam int   DIRECTED_ROWS   = 25;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              ready;
  } answer_t;

  typedef struct packed {
    logic              act;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
    logic              typed;
    logic [WORD_W-1:0] want_data;
    logic              want_ready;
  } probe_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_action;
  logic [ADDR_W-1:0] in_address;
  logic [WORD_W-1:0] in_write_data;
  logic              out_valid;
  logic              out_stall;
  logic [WORD_W-1:0] out_read_data;
  logic              out_ready_res;
  logic              cfg_write_en;
  logic [VID_W-1:0]  cfg_write_data;

  audio_codec_register_file_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data),
    .out_ready_res (out_ready_res),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  // Model state
  logic [WORD_W-1:0] mixer_words [WORD_COUNT];
  logic [VID_W-1:0]  vendor_reg;
  answer_t           pending_answers[$];
  int                mismatch_count = 0;
  int                idle_cycles = 0;

  probe_t directed_rows [DIRECTED_ROWS] = '{
    '{ACT_READ,  8'h02, 16'h0000, 1'b1, 16'h8000, 1'b1},
    '{ACT_READ,  ADDR_PWR_STATUS, 16'hffff, 1'b1, 16'h000f, 1'b1},
    '{ACT_READ,  ADDR_DAC_RATE, 16'h0000, 1'b1, 16'd48000, 1'b1},
    // ID words stay clear until a reload
    '{ACT_READ,  ADDR_VID_HI, 16'h0000, 1'b1, 16'h0000, 1'b1},
    '{ACT_READ,  ADDR_VID_LO, 16'h0000, 1'b1, 16'h0000, 1'b1},
    '{ACT_WRITE, 8'h04, 16'hffff, 1'b1, 16'h0000, 1'b0},
    '{ACT_READ,  8'h04, 16'h0000, 1'b1, 16'hffff, 1'b1},
    '{ACT_WRITE, ADDR_PWR_STATUS, 16'h0000, 1'b1, 16'h0000, 1'b0},
    '{ACT_READ,  ADDR_PWR_STATUS, 16'h0000, 1'b1, 16'h000f, 1'b1},
    '{ACT_WRITE, ADDR_PWR_STATUS, 16'hfff0, 1'b1, 16'h0000, 1'b0},
    '{ACT_READ,  ADDR_PWR_STATUS, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ACT_WRITE, ADDR_EXT_ID, 16'h1234, 1'b1, 16'h0000, 1'b0},
    '{ACT_READ,  ADDR_EXT_ID, 16'h0000, 1'b1, 16'h0000, 1'b1},
    '{ACT_WRITE, ADDR_DAC_RATE, 16'h0000, 1'b1, 16'h0000, 1'b0},
    '{ACT_READ,  ADDR_DAC_RATE, 16'h0000, 1'b1, 16'd48000, 1'b1},
    // aliases of special words store as given
    '{ACT_WRITE, 8'hac, 16'h5555, 1'b1, 16'h0000, 1'b0},
    '{ACT_READ,  ADDR_DAC_RATE, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ACT_WRITE, 8'h27, 16'h0000, 1'b1, 16'h0000, 1'b0},
    '{ACT_READ,  ADDR_PWR_STATUS, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ACT_WRITE, 8'h80, 16'h0001, 1'b1, 16'h0000, 1'b0},
    '{ACT_READ,  ADDR_RESET, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ACT_WRITE, ADDR_RESET, 16'hffff, 1'b1, 16'h0000, 1'b0},
    '{ACT_READ,  ADDR_VID_HI, 16'h0000, 1'b1, 16'h1234, 1'b1},
    '{ACT_READ,  ADDR_VID_LO, 16'h0000, 1'b1, 16'habcd, 1'b1},
    '{ACT_READ,  8'h04, 16'h0000, 1'b1, 16'h0000, 1'b1}
  };

  function automatic void restore_defaults();
    mixer_words = '{default: '0};
    mixer_words[W_MASTER]     = 16'h8000;
    mixer_words[W_MONO]       = 16'h8000;
    mixer_words[W_REC_GAIN]   = 16'h8000;
    mixer_words[W_PHONE]      = 16'h8008;
    mixer_words[W_MIC]        = 16'h8008;
    mixer_words[W_LINE]       = 16'h8808;
    mixer_words[W_CD]         = 16'h8808;
    mixer_words[W_PCM]        = 16'h8808;
    mixer_words[W_PWR_STATUS] = 16'h000f;
    mixer_words[W_DAC_RATE]   = 16'd48000;
    mixer_words[W_ADC_RATE]   = 16'd48000;
    mixer_words[W_MIC_RATE]   = 16'd48000;
    mixer_words[W_VID_HI]     = vendor_reg[31:16];
    mixer_words[W_VID_LO]     = vendor_reg[15:0];
  endfunction

  function automatic answer_t mixer_access(input logic act, input logic [ADDR_W-1:0] addr,
                                           input logic [WORD_W-1:0] data);
    answer_t          ans;
    logic [IDX_W-1:0] idx;
    idx = word_idx(addr);
    if (act == ACT_READ) begin
      ans.read_data = mixer_words[idx];
      ans.ready     = 1'b1;
      return ans;
    end
    case (addr)
      ADDR_RESET:      restore_defaults();
      ADDR_PWR_STATUS: mixer_words[idx] = data | 16'h000f;
      ADDR_EXT_ID, ADDR_DAC_RATE, ADDR_ADC_RATE, ADDR_MIC_RATE,
      ADDR_VID_HI, ADDR_VID_LO: ;
      default:         mixer_words[idx] = data;
    endcase
    ans.read_data = '0;
    ans.ready     = 1'b0;
    return ans;
  endfunction

  // About 40 percent special words and their aliases; the rest spans the whole byte range
  function automatic logic [ADDR_W-1:0] pick_address();
    logic [ADDR_W-1:0] hot [8];
    logic [ADDR_W-1:0] a;
    int                r;
    hot = '{ADDR_RESET, ADDR_PWR_STATUS, ADDR_EXT_ID, ADDR_DAC_RATE,
            ADDR_ADC_RATE, ADDR_MIC_RATE, ADDR_VID_HI, ADDR_VID_LO};
    r = $urandom_range(0, 99);
    if (r < 3) return ADDR_RESET;
    if (r < 40) begin
      a = hot[3'($urandom_range(0, 7))];
      case ($urandom_range(0, 3))
        1: a = a ^ 8'h80;
        2: a = a ^ 8'h01;
        3: a = a ^ 8'h81;
        default: ;
      endcase
      return a;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Offers one transaction and waits until it is taken; valid stays high on return.
  task automatic send_request(input logic act, input logic [ADDR_W-1:0] addr,
                              input logic [WORD_W-1:0] data, input logic typed,
                              input logic [WORD_W-1:0] want_data, input logic want_ready);
    answer_t ans;
    in_valid      <= 1'b1;
    in_action     <= act;
    in_address    <= addr;
    in_write_data <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ans = mixer_access(act, addr, data);
    if (typed) begin
      ans.read_data = want_data;
      ans.ready     = want_ready;
    end
    pending_answers.push_back(ans);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic load_vendor_id(input logic [VID_W-1:0] v);
    drain();
    repeat (3) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    vendor_reg = v;
  endtask

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Result check
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected transaction", out_read_data, '0);
      end else begin
        want = pending_answers.pop_front();
        if (out_read_data !== want.read_data)
          report_mismatch("read_data", out_read_data, want.read_data);
        if (out_ready_res !== want.ready)
          report_mismatch("ready_res", {15'b0, out_ready_res}, {15'b0, want.ready});
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d answers pending", pending_answers.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: long hold-off first so the block backs up, then mixed segments
  initial begin
    int len;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    out_stall <= 1'b1;
    repeat (120) @(posedge clk);
    forever begin
      len = $urandom_range(10, 60);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          out_stall <= 1'b0;
          repeat (len) @(posedge clk);
        end
        9: begin
          out_stall <= 1'b1;
          repeat ($urandom_range(40, 120)) @(posedge clk);
        end
        default: begin
          repeat (len) begin
            out_stall <= ($urandom_range(0, 2) == 0);
            @(posedge clk);
          end
        end
      endcase
    end
  end

  // Sender
  initial begin
    logic [VID_W-1:0]  phase_vid [5];
    logic              act;
    logic [WORD_W-1:0] data;
    int                sent;
    int                burst;
    int                gap;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_action      <= ACT_READ;
    in_address     <= '0;
    in_write_data  <= '0;
    cfg_write_en   <= 1'b0;
    cfg_write_data <= '0;
    vendor_reg = '0;
    restore_defaults();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_vendor_id(32'h1234_abcd);
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].act, directed_rows[i].addr, directed_rows[i].data,
                   directed_rows[i].typed, directed_rows[i].want_data,
                   directed_rows[i].want_ready);
      if ($urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end

    phase_vid = '{32'h0000_0000, 32'hffff_ffff, 32'($urandom), 32'h8000_0001, 32'($urandom)};
    foreach (phase_vid[p]) begin
      load_vendor_id(phase_vid[p]);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
        for (int k = 0; k < burst && sent < ITEMS_PER_PHASE; k++) begin
          act = $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
          case ($urandom_range(0, 9))
            0:       data = 16'h0000;
            1:       data = 16'hffff;
            default: data = 16'($urandom_range(0, 65535));
          endcase
          send_request(act, pick_address(), data, 1'b0, '0, 1'b0);
          sent++;
        end
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
